// File: rtl/core/cps_pkg.sv
package cps_pkg;

  localparam int CPS_DEPTH = 64;
  localparam int SAMPLE_W  = 32;
  localparam int FRAC_W    = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_FRACTION  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LIMIT_EN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LIMIT_VAL = 2'd2;

  localparam logic [FRAC_W-1:0]   FRACTION_RST  = 16'h8000;
  localparam logic signed [SAMPLE_W-1:0] LIMIT_VAL_RST = 32'sh7FFF_FFFF;

  // Link from one cell to its right-hand neighbor.
  typedef struct packed {
    logic                       valid;
    logic                       gt;
    logic signed [SAMPLE_W-1:0] value;
  } cell_link_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RANK,
    ST_PICK
  } cps_state_t;

endpackage

// File: rtl/core/column_percentile_select_core.sv
// Channel | Ports                                      | Handshake
// --------+--------------------------------------------+-----------------------------
// in      | in_sample, in_last_sample                  | start & !busy accepts item
// out     | out_percentile_value, out_empty_column,    | out_valid strobe, one cycle
//         | out_overflow                               |
// cfg     | cfg_index, cfg_data                        | cfg_valid & cfg_ready
//
// One item per cycle while a column streams in: each kept item is inserted into a
// row of DEPTH sorting cells, while one is free, in the cycle it is accepted.
// An item with last_sample set is inserted, then goes through the rank multiply
// (ST_RANK) and the cell pick (ST_PICK); busy stays high in both states and
// the result strobes once the core is back in ST_IDLE, when the next item may enter.
// Reset (synchronous, rst_n low) empties the cells and loads register defaults.
// The receiver cannot stall: each result is shown for exactly one cycle.
module column_percentile_select_core
  import cps_pkg::*;
#(
  parameter int DEPTH = CPS_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // item input
  input  logic                        start,
  output logic                        busy,
  input  logic signed [SAMPLE_W-1:0]  in_sample,
  input  logic                        in_last_sample,
  // result output
  output logic                        out_valid,
  output logic signed [SAMPLE_W-1:0]  out_percentile_value,
  output logic                        out_empty_column,
  output logic                        out_overflow,
  // configuration
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [SAMPLE_W-1:0]         cfg_data
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW = FRAC_W + CW;

  // configuration registers
  logic [FRAC_W-1:0]          frac_r;
  logic                       limit_en_r;
  logic signed [SAMPLE_W-1:0] limit_val_r;

  // column state
  cps_state_t                 state_r, state_nxt;
  logic [CW-1:0]              count_r, count_nxt;
  logic                       ovf_r, ovf_nxt;
  logic [PW-1:0]              prod_r;

  // result registers
  logic                       out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_W-1:0] out_value_r, out_value_nxt;
  logic                       out_empty_r, out_empty_nxt;
  logic                       out_ovf_r, out_ovf_nxt;

  logic                       accept;
  logic                       keep;
  logic                       full;
  logic                       ins;
  logic                       clear;
  logic [CW-1:0]              rank_raw;
  logic [CW-1:0]              rank;
  logic signed [SAMPLE_W-1:0] pick_value;

  assign cfg_ready = 1'b1;
  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;

  // drop items at or above the limit when it is enabled
  assign keep = !limit_en_r || (in_sample < limit_val_r);
  assign full = (count_r == CW'(DEPTH));
  assign ins  = accept && keep && !full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frac_r      <= FRACTION_RST;
      limit_en_r  <= 1'b0;
      limit_val_r <= LIMIT_VAL_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_IDX_FRACTION:  frac_r      <= cfg_data[FRAC_W-1:0];
        CFG_IDX_LIMIT_EN:  limit_en_r  <= cfg_data[0];
        CFG_IDX_LIMIT_VAL: limit_val_r <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // rank = floor(fraction * count / 2^16), clamped to count-1
  assign rank_raw = prod_r[PW-1:FRAC_W];
  assign rank     = (rank_raw >= count_r) ? (count_r - CW'(1)) : rank_raw;

  cps_chain #(
    .DEPTH (DEPTH),
    .IW    (IW)
  ) u_chain (
    .clk      (clk),
    .rst_n    (rst_n),
    .clear    (clear),
    .ins      (ins),
    .sample   (in_sample),
    .rd_idx   (rank[IW-1:0]),
    .rd_value (pick_value)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    clear         = 1'b0;
    out_valid_nxt = 1'b0;
    out_value_nxt = out_value_r;
    out_empty_nxt = out_empty_r;
    out_ovf_nxt   = out_ovf_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (ins) begin
            count_nxt = count_r + CW'(1);
          end
          if (keep && full) begin
            ovf_nxt = 1'b1;
          end
          if (in_last_sample) begin
            state_nxt = ST_RANK;
          end
        end
      end
      ST_RANK: begin
        // hold while the rank product settles in prod_r
        state_nxt = ST_PICK;
      end
      ST_PICK: begin
        out_valid_nxt = 1'b1;
        out_ovf_nxt   = ovf_r;
        if (count_r == '0) begin
          out_value_nxt = limit_val_r;
          out_empty_nxt = 1'b1;
        end else begin
          out_value_nxt = pick_value;
          out_empty_nxt = 1'b0;
        end
        // drop the column
        clear     = 1'b1;
        count_nxt = '0;
        ovf_nxt   = 1'b0;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r      <= PW'(frac_r) * PW'(count_r);
    out_value_r <= out_value_nxt;
    out_empty_r <= out_empty_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_percentile_value = out_value_r;
  assign out_empty_column     = out_empty_r;
  assign out_overflow         = out_ovf_r;

endmodule

// File: rtl/core/cps_cell.sv
module cps_cell
  import cps_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       clear,
  input  logic                       ins,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  cell_link_t                 left,
  output cell_link_t                 right
);

  logic                       valid_r, valid_nxt;
  logic signed [SAMPLE_W-1:0] value_r, value_nxt;
  logic                       gt;

  assign gt = valid_r && (value_r > sample);

  always_comb begin
    value_nxt = value_r;
    valid_nxt = valid_r;
    if (clear) begin
      valid_nxt = 1'b0;
    end else if (ins) begin
      // shift right when the left neighbor is larger, else take the new item
      // at the insertion point
      if (left.gt) begin
        value_nxt = left.value;
      end else if (gt || (!valid_r && left.valid)) begin
        value_nxt = sample;
      end
      valid_nxt = valid_r || left.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign right.valid = valid_r;
  assign right.gt    = gt;
  assign right.value = value_r;

endmodule

// File: rtl/core/cps_chain.sv
module cps_chain
  import cps_pkg::*;
#(
  parameter int DEPTH = CPS_DEPTH,
  parameter int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       clear,
  input  logic                       ins,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic [IW-1:0]              rd_idx,
  output logic signed [SAMPLE_W-1:0] rd_value
);

  cell_link_t links [DEPTH+1];

  // Head of the chain: always "valid", never larger than the new item.
  assign links[0].valid = 1'b1;
  assign links[0].gt    = 1'b0;
  assign links[0].value = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cps_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .clear  (clear),
      .ins    (ins),
      .sample (sample),
      .left   (links[i]),
      .right  (links[i+1])
    );
  end

  always_comb begin
    rd_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (rd_idx == IW'(i)) begin
        rd_value = links[i+1].value;
      end
    end
  end

endmodule

// File: tb/percentile_check_pkg.sv
package percentile_check_pkg;
  import cps_pkg::*;

  // Index 3 is not a register: writes to it must leave every setting alone.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

  typedef struct {
    logic signed [SAMPLE_W-1:0] value;
    logic                       empty;
    logic                       ovf;
  } percentile_result_t;

  // Track the sorted column and the register settings, and queue the
  // percentile that each finished column should produce.
  class percentile_tracker;
    logic [FRAC_W-1:0]          fraction;
    logic                       limit_en;
    logic signed [SAMPLE_W-1:0] limit_val;
    logic signed [SAMPLE_W-1:0] sorted_col[CPS_DEPTH];
    int unsigned                kept;
    logic                       ovf_seen;
    percentile_result_t         pending_percentiles[$];
    int                         errors;

    function new();
      fraction  = FRACTION_RST;
      limit_en  = 1'b0;
      limit_val = LIMIT_VAL_RST;
      kept      = 0;
      ovf_seen  = 1'b0;
      errors    = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [SAMPLE_W-1:0] data);
      case (idx)
        CFG_IDX_FRACTION:  fraction  = data[FRAC_W-1:0];
        CFG_IDX_LIMIT_EN:  limit_en  = data[0];
        CFG_IDX_LIMIT_VAL: limit_val = data;
        default: ;
      endcase
    endfunction

    function void take_sample(logic signed [SAMPLE_W-1:0] s, logic last);
      int unsigned        pos;
      int unsigned        rank;
      percentile_result_t r;
      if (!limit_en || s < limit_val) begin
        if (kept < CPS_DEPTH) begin
          pos = kept;
          while (pos > 0 && sorted_col[pos-1] > s) begin
            sorted_col[pos] = sorted_col[pos-1];
            pos--;
          end
          sorted_col[pos] = s;
          kept++;
        end else begin
          ovf_seen = 1'b1;
        end
      end
      if (!last) return;
      if (kept == 0) begin
        r.value = limit_val;
        r.empty = 1'b1;
      end else begin
        rank = (32'(fraction) * kept) >> 16;
        if (rank > kept - 1) rank = kept - 1;
        r.value = sorted_col[rank];
        r.empty = 1'b0;
      end
      r.ovf = ovf_seen;
      pending_percentiles.push_back(r);
      kept     = 0;
      ovf_seen = 1'b0;
    endfunction

    function void check_percentile(logic signed [SAMPLE_W-1:0] value, logic empty,
                                   logic ovf);
      percentile_result_t r;
      if (pending_percentiles.size() == 0) begin
        $error("result with no column pending: percentile_value %0d", value);
        errors++;
        return;
      end
      r = pending_percentiles.pop_front();
      if (value !== r.value) begin
        $error("percentile_value: expected %0d, got %0d", r.value, value);
        errors++;
      end
      if (empty !== r.empty) begin
        $error("empty_column: expected %0b, got %0b", r.empty, empty);
        errors++;
      end
      if (ovf !== r.ovf) begin
        $error("overflow: expected %0b, got %0b", r.ovf, ovf);
        errors++;
      end
    endfunction

    function int pending();
      return pending_percentiles.size();
    endfunction
  endclass

endpackage

// File: tb/tb.sv
module tb;
  import cps_pkg::*;
  import percentile_check_pkg::*;

  localparam int TARGET_ITEMS = 1550;
  // Past this many items, send back to back so the tail runs at full rate.
  localparam int CALM_TAIL    = 1300;

  logic                       clk;
  logic                       rst_n;
  logic                       start;
  logic                       busy;
  logic signed [SAMPLE_W-1:0] in_sample;
  logic                       in_last_sample;
  logic                       out_valid;
  logic signed [SAMPLE_W-1:0] out_percentile_value;
  logic                       out_empty_column;
  logic                       out_overflow;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [SAMPLE_W-1:0]        cfg_data;

  percentile_tracker tracker;
  int  items_sent;
  bit  idle_on;

  column_percentile_select_core dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_sample            (in_sample),
    .in_last_sample       (in_last_sample),
    .out_valid            (out_valid),
    .out_percentile_value (out_percentile_value),
    .out_empty_column     (out_empty_column),
    .out_overflow         (out_overflow),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: far beyond the slowest legal run (every item after the longest
  // pause plus the rank and pick on every column end).
  initial begin
    #3000000;
    $display("DONE: errors detected");
    $finish;
  end

  // Observe every handshake at the rising edge. Check the result before
  // noting a new item: a strobe and the next acceptance can share an edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid)
        tracker.check_percentile(out_percentile_value, out_empty_column, out_overflow);
      if (start && !busy)
        tracker.take_sample(in_sample, in_last_sample);
      if (cfg_valid && cfg_ready)
        tracker.write_reg(cfg_index, cfg_data);
    end
  end

  // Present one item at the falling edge and hold it until busy is low.
  task automatic send_item(input logic signed [SAMPLE_W-1:0] s, input logic last);
    @(negedge clk);
    start          <= 1'b1;
    in_sample      <= s;
    in_last_sample <= last;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  // Drop start for a pause of length n; scramble the data so an ignored item is visible.
  task automatic pause(input int n);
    @(negedge clk);
    start          <= 1'b0;
    in_sample      <= $urandom;
    in_last_sample <= $urandom_range(0, 1);
    repeat (n - 1) @(negedge clk);
  endtask

  // Go quiet and wait out the pick of the last column before touching registers.
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [SAMPLE_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mix full-range values, tight clusters that force duplicates, values that
  // straddle the current limit, and the two extremes.
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return int'($urandom_range(0, 16)) - 8;
      2: return tracker.limit_val + (int'($urandom_range(0, 6)) - 3);
      default: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    endcase
  endfunction

  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 8);
    if (r < 88) return $urandom_range(9, 40);
    if (r < 94) return $urandom_range(63, 65);
    return $urandom_range(50, 72);
  endfunction

  // Stream one column; gaps come in random bursts while idling is on, before the calm tail.
  task automatic send_column(input int len);
    for (int i = 0; i < len; i++) begin
      if (idle_on && items_sent < CALM_TAIL && $urandom_range(0, 3) == 0)
        pause($urandom_range(1, 12));
      send_item(pick_sample(), i == len - 1);
    end
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_fraction();
    case ($urandom_range(0, 4))
      0: return 0;
      1: return 16'hFFFF;
      2: return FRACTION_RST;
      default: return $urandom_range(0, 16'hFFFF);
    endcase
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_limit();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 0;
      3: return int'($urandom_range(0, 16)) - 8;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int n_cols;
    tracker        = new();
    items_sent     = 0;
    idle_on        = 1'b0;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_sample      = '0;
    in_last_sample = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = CFG_IDX_FRACTION;
    cfg_data       = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset settings: median, no limit. Single-sample columns at both extremes.
    send_item(32'sh7FFF_FFFF, 1'b1);
    send_item(32'sh8000_0000, 1'b1);
    // Unsorted arrival, then equal samples.
    send_item(5, 1'b0);
    send_item(-3, 1'b0);
    send_item(0, 1'b1);
    send_item(7, 1'b0);
    send_item(7, 1'b1);

    // Lowest and highest fractions over the same column.
    settle();
    cfg_write(CFG_IDX_FRACTION, 0);
    send_item(40, 1'b0);
    send_item(-40, 1'b0);
    send_item(12, 1'b1);
    settle();
    cfg_write(CFG_IDX_FRACTION, 16'hFFFF);
    send_item(40, 1'b0);
    send_item(-40, 1'b0);
    send_item(12, 1'b1);

    // Limit at zero: drop samples at or above it, then a column that empties.
    settle();
    cfg_write(CFG_IDX_LIMIT_EN, 1);
    cfg_write(CFG_IDX_LIMIT_VAL, 0);
    cfg_write(CFG_IDX_UNUSED, $urandom);
    send_item(-1, 1'b0);
    send_item(0, 1'b0);
    send_item(100, 1'b1);
    send_item(5, 1'b1);
    send_item(32'sh7FFF_FFFF, 1'b0);
    send_item(32'sh8000_0000, 1'b1);

    // Random phases: fresh settings each phase, then a run of columns.
    while (items_sent < TARGET_ITEMS) begin
      settle();
      cfg_write(CFG_IDX_FRACTION, pick_fraction());
      cfg_write(CFG_IDX_LIMIT_EN, ($urandom_range(0, 2) == 0) ? 32'h1 : 32'h0);
      cfg_write(CFG_IDX_LIMIT_VAL, pick_limit());
      if ($urandom_range(0, 3) == 0)
        cfg_write(CFG_IDX_UNUSED, $urandom);
      idle_on = ($urandom_range(0, 3) != 0);
      n_cols  = $urandom_range(6, 16);
      for (int c = 0; c < n_cols && items_sent < TARGET_ITEMS; c++)
        send_column(pick_length());
    end

    // Drain: wait for every column result, then allow the pick latency.
    @(negedge clk);
    start <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
